[hw/rtl/skb_pkg.sv]
// Shared constants, types and codes for the sorted key bucket.
package skb_pkg;

    localparam int CAPACITY     = 16;
    localparam int PAYLOAD_BITS = 32;
    localparam int KEY_W        = 32;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int CNT_OUT_W    = 5;
    localparam int STATUS_W     = 2;
    localparam int OP_W         = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [PAYLOAD_BITS-1:0] pay_t;

    typedef struct packed {
        logic do_ins;
        logic do_rem;
    } cell_cmd_t;

endpackage

[hw/rtl/skb_cell.sv]
// One list slot: holds a key and payload, compares and shifts with its neighbors.
module skb_cell (
    input  logic               clk,
    input  logic               occ,
    input  skb_pkg::cell_cmd_t cmd,
    input  skb_pkg::key_t      op_key,
    input  skb_pkg::pay_t      op_pay,
    input  skb_pkg::key_t      left_key,
    input  skb_pkg::pay_t      left_pay,
    input  logic               left_pos,
    input  skb_pkg::key_t      right_key,
    input  skb_pkg::pay_t      right_pay,
    input  logic               prev_match,
    output skb_pkg::key_t      key,
    output skb_pkg::pay_t      pay,
    output logic               pos,
    output logic               match,
    output skb_pkg::pay_t      hit_pay
);

    skb_pkg::key_t key_reg;
    skb_pkg::key_t key_next;
    skb_pkg::pay_t pay_reg;
    skb_pkg::pay_t pay_next;
    logic          ge;
    logic          le;

    assign ge      = op_key >= key_reg;
    assign le      = key_reg <= op_key;
    assign match   = occ && (op_key == key_reg);
    assign pos     = occ ? ge : 1'b1;
    assign hit_pay = (match && !prev_match) ? pay_reg : '0;
    assign key     = key_reg;
    assign pay     = pay_reg;

    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (cmd.do_ins)
        begin
            if (left_pos)
            begin
                key_next = left_key;
                pay_next = left_pay;
            end
            else if (pos)
            begin
                key_next = op_key;
                pay_next = op_pay;
            end
        end
        else if (cmd.do_rem && le)
        begin
            key_next = right_key;
            pay_next = right_pay;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

endmodule

[hw/rtl/sorted_key_bucket.sv]
// An accepted item is registered, then executed once the result register is free;
// its result is registered at execution. Throughput: one item per cycle while the
// result side keeps up; every cell compares against the key and, on an insert or a
// remove, shifts one place. Reset clears the fill count and the handshake state;
// entry contents are not cleared and are never read before being written.
module sorted_key_bucket (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // key[31:0], payload[63:32]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // payload_out[31:0], entry_count[36:32], zero[39:37]
    output logic [2:0]  m_tuser    // found[0], status[2:1]
);

    localparam int N  = skb_pkg::CAPACITY;
    localparam int CW = skb_pkg::CNT_W;
    localparam int PB = skb_pkg::PAYLOAD_BITS;

    logic                              busy_reg;
    logic                              busy_next;
    logic [skb_pkg::OP_W-1:0]          op_reg;
    skb_pkg::key_t                     key_reg;
    skb_pkg::pay_t                     pay_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     count_next;
    logic                              m_valid_reg;
    logic                              m_valid_next;
    logic                              found_reg;
    logic [31:0]                       pout_reg;
    logic [skb_pkg::STATUS_W-1:0]      status_reg;
    logic [skb_pkg::CNT_OUT_W-1:0]     cnt_out_reg;

    logic                              accept;
    logic                              exec;
    logic                              full;
    logic                              found;
    logic [PB+31:0]                    pay_in_wide;
    logic [PB+31:0]                    hit_wide;
    logic [CW+skb_pkg::CNT_OUT_W-1:0]  cnt_wide;
    logic [skb_pkg::STATUS_W-1:0]      status_next;
    skb_pkg::cell_cmd_t                cmd;
    skb_pkg::pay_t                     hit_any;

    skb_pkg::key_t                     c_key   [N];
    skb_pkg::pay_t                     c_pay   [N];
    logic [N-1:0]                      c_pos;
    logic [N-1:0]                      c_match;
    logic [N-1:0]                      c_occ;
    skb_pkg::pay_t                     c_hit   [N];

    assign exec     = busy_reg && (!m_valid_reg || m_tready);
    assign s_tready = !busy_reg || exec;
    assign accept   = s_tvalid && s_tready;
    assign full     = count_reg == CW'(N);
    assign found    = |c_match;

    assign pay_in_wide = {{PB{1'b0}}, s_tdata[63:32]};

    assign cmd.do_ins = exec && (op_reg == skb_pkg::OP_INSERT) && !full;
    assign cmd.do_rem = exec && (op_reg == skb_pkg::OP_REMOVE) && found;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            assign c_occ[gi] = count_reg > CW'(gi);
            if (gi == 0)
            begin : g_first
                skb_cell u_cell (
                    .clk        (clk),
                    .occ        (c_occ[gi]),
                    .cmd        (cmd),
                    .op_key     (key_reg),
                    .op_pay     (pay_reg),
                    .left_key   ('0),
                    .left_pay   ('0),
                    .left_pos   (1'b0),
                    .right_key  (c_key[gi+1]),
                    .right_pay  (c_pay[gi+1]),
                    .prev_match (1'b0),
                    .key        (c_key[gi]),
                    .pay        (c_pay[gi]),
                    .pos        (c_pos[gi]),
                    .match      (c_match[gi]),
                    .hit_pay    (c_hit[gi])
                );
            end
            else if (gi == N - 1)
            begin : g_last
                skb_cell u_cell (
                    .clk        (clk),
                    .occ        (c_occ[gi]),
                    .cmd        (cmd),
                    .op_key     (key_reg),
                    .op_pay     (pay_reg),
                    .left_key   (c_key[gi-1]),
                    .left_pay   (c_pay[gi-1]),
                    .left_pos   (c_pos[gi-1]),
                    .right_key  ('0),
                    .right_pay  ('0),
                    .prev_match (c_match[gi-1]),
                    .key        (c_key[gi]),
                    .pay        (c_pay[gi]),
                    .pos        (c_pos[gi]),
                    .match      (c_match[gi]),
                    .hit_pay    (c_hit[gi])
                );
            end
            else
            begin : g_mid
                skb_cell u_cell (
                    .clk        (clk),
                    .occ        (c_occ[gi]),
                    .cmd        (cmd),
                    .op_key     (key_reg),
                    .op_pay     (pay_reg),
                    .left_key   (c_key[gi-1]),
                    .left_pay   (c_pay[gi-1]),
                    .left_pos   (c_pos[gi-1]),
                    .right_key  (c_key[gi+1]),
                    .right_pay  (c_pay[gi+1]),
                    .prev_match (c_match[gi-1]),
                    .key        (c_key[gi]),
                    .pay        (c_pay[gi]),
                    .pos        (c_pos[gi]),
                    .match      (c_match[gi]),
                    .hit_pay    (c_hit[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        hit_any = '0;
        for (int i = 0; i < N; i++)
        begin
            hit_any = hit_any | c_hit[i];
        end
    end

    assign hit_wide = {32'b0, hit_any};

    always_comb
    begin
        count_next  = count_reg;
        status_next = skb_pkg::ST_DONE;
        case (op_reg)
            skb_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = skb_pkg::ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            skb_pkg::OP_LOOKUP:
            begin
                if (!found)
                begin
                    status_next = skb_pkg::ST_MISSING;
                end
            end
            skb_pkg::OP_REMOVE:
            begin
                if (found)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = skb_pkg::ST_MISSING;
                end
            end
            default:
            begin
                count_next = '0;
            end
        endcase
    end

    assign cnt_wide = {{skb_pkg::CNT_OUT_W{1'b0}}, count_next};

    assign busy_next    = accept ? 1'b1 : (exec ? 1'b0 : busy_reg);
    assign m_valid_next = exec ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
            if (exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= s_tuser;
            key_reg <= s_tdata[31:0];
            pay_reg <= pay_in_wide[PB-1:0];
        end
        if (exec)
        begin
            found_reg   <= found && (op_reg == skb_pkg::OP_LOOKUP || op_reg == skb_pkg::OP_REMOVE);
            pout_reg    <= (op_reg == skb_pkg::OP_LOOKUP) ? hit_wide[31:0] : 32'd0;
            status_reg  <= status_next;
            cnt_out_reg <= cnt_wide[skb_pkg::CNT_OUT_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b0, cnt_out_reg, pout_reg};
    assign m_tuser  = {status_reg, found_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(N))
        else $error("fill count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_ins |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    assert property (@(posedge clk) disable iff (!rst_n)
        exec && op_reg == skb_pkg::OP_INSERT && full |=> m_tuser[2:1] == skb_pkg::ST_FULL)
        else $error("drop on full list not flagged");

    assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> m_tvalid)
        else $error("executed item produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == skb_pkg::ST_DONE)
        else $error("hit reported with non-done status");

endmodule

[tb/tb_sorted_key_bucket.sv]
// Testbench for sorted_key_bucket: queued stimulus driver, predicting monitor, watchdog.
`timescale 1ns / 100ps

module tb_sorted_key_bucket;
    import skb_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_LEN    = 300;
    localparam int PHASE_ITEMS = 480;
    localparam int POOL_SIZE   = 6;

    typedef struct {
        logic [OP_W-1:0] op;
        key_t            key;
        logic [31:0]     pay;
        int              phase;
        bit              drain;
        bit              hold;
    } bucket_req_t;

    typedef struct {
        logic                found;
        logic [31:0]         payload_out;
        logic [STATUS_W-1:0] status;
        logic [CNT_OUT_W-1:0] entry_count;
    } bucket_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    int tx_idle_pct [3] = '{21, 79, 0};
    int rx_idle_pct [3] = '{79, 21, 0};

    bucket_req_t    req_queue [$];
    bucket_result_t expected_results [$];

    key_t bucket_keys [CAPACITY];
    pay_t bucket_pays [CAPACITY];
    int   held_count = 0;

    int   offered_phase  = 0;
    bit   offered_hold   = 1'b0;
    int   rx_phase       = 0;
    bit   hold_start     = 1'b0;
    int   hold_left      = 0;
    bit   results_quiet  = 1'b1;
    int   mismatch_count = 0;
    int   stall_cycles   = 0;

    sorted_key_bucket DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic bucket_result_t apply_bucket_op(logic [OP_W-1:0] op, key_t k, pay_t p);
        bucket_result_t r;
        int pos;
        int i;
        bit hunting;
        r.found       = 1'b0;
        r.payload_out = '0;
        r.status      = ST_DONE;
        pos           = held_count;
        case (op)
            OP_INSERT:
            begin
                if (held_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    hunting = 1'b1;
                    for (i = 0; i < held_count; i++)
                        if (hunting && k >= bucket_keys[i])
                        begin
                            pos     = i;
                            hunting = 1'b0;
                        end
                    for (i = held_count; i > pos; i--)
                    begin
                        bucket_keys[i] = bucket_keys[i-1];
                        bucket_pays[i] = bucket_pays[i-1];
                    end
                    bucket_keys[pos] = k;
                    bucket_pays[pos] = p;
                    held_count++;
                end
            end
            OP_LOOKUP, OP_REMOVE:
            begin
                for (i = 0; i < held_count; i++)
                    if (pos == held_count && bucket_keys[i] == k)
                        pos = i;
                if (pos == held_count)
                    r.status = ST_MISSING;
                else
                begin
                    r.found = 1'b1;
                    if (op == OP_LOOKUP)
                        r.payload_out = 32'(bucket_pays[pos]);
                    else
                    begin
                        for (i = pos; i + 1 < held_count; i++)
                        begin
                            bucket_keys[i] = bucket_keys[i+1];
                            bucket_pays[i] = bucket_pays[i+1];
                        end
                        held_count--;
                    end
                end
            end
            OP_CLEAR:
                held_count = 0;
        endcase
        r.entry_count = CNT_OUT_W'(held_count);
        return r;
    endfunction

    task automatic add_req(logic [OP_W-1:0] op, key_t k, logic [31:0] p, int phase,
                           bit drain, bit hold);
        bucket_req_t q;
        q.op    = op;
        q.key   = k;
        q.pay   = p;
        q.phase = phase;
        q.drain = drain;
        q.hold  = hold;
        req_queue = {req_queue, q};
    endtask

    // Sender: advance to the next pending transfer, hold a drain item until results are in.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (req_queue.size() != 0
                && !(req_queue[0].drain && (s_tvalid || !results_quiet))
                && $urandom_range(99) >= tx_idle_pct[req_queue[0].phase])
            begin
                s_tvalid      <= 1'b1;
                s_tdata       <= {req_queue[0].pay, req_queue[0].key};
                s_tuser       <= req_queue[0].op;
                offered_phase <= req_queue[0].phase;
                offered_hold  <= req_queue[0].hold;
                void'(req_queue.pop_front());
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random backpressure plus a long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (hold_start)
                hold_left <= HOLD_LEN;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            m_tready <= !hold_start && hold_left == 0
                        && $urandom_range(99) >= rx_idle_pct[rx_phase];
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        bucket_result_t exp_r;
        if (!rst_n)
        begin
            results_quiet <= 1'b1;
            hold_start    <= 1'b0;
            rx_phase      <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: found=%0d pay=%h st=%0d cnt=%0d",
                                 m_tuser[0], m_tdata[31:0], m_tuser[2:1], m_tdata[36:32]);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser[0] !== exp_r.found || m_tdata[31:0] !== exp_r.payload_out
                        || m_tuser[2:1] !== exp_r.status
                        || m_tdata[36:32] !== exp_r.entry_count)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("mismatch: exp found=%0d pay=%h st=%0d cnt=%0d,",
                                   exp_r.found, exp_r.payload_out, exp_r.status,
                                   exp_r.entry_count);
                            $display(" got found=%0d pay=%h st=%0d cnt=%0d",
                                     m_tuser[0], m_tdata[31:0], m_tuser[2:1],
                                     m_tdata[36:32]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results = {expected_results,
                                    apply_bucket_op(s_tuser, s_tdata[31:0], s_tdata[63:32])};
                rx_phase <= offered_phase;
            end
            hold_start    <= s_tvalid && s_tready && offered_hold;
            results_quiet <= expected_results.size() == 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        key_t key_pool [POOL_SIZE];
        key_t k;
        int   ph;
        int   n;
        int   j;
        int   r;

        add_req(OP_LOOKUP, 32'sd0, 32'h1234_5678, 0, 1'b0, 1'b0);
        add_req(OP_REMOVE, -32'sd1, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, 32'h8000_0000, 32'h0000_0000, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, 32'sd0, 32'hA5A5_A5A5, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, 32'sd0, 32'h5A5A_5A5A, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, -32'sd1, 32'hC3C3_3C3C, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, 32'sd0, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, 32'h8000_0000, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, -32'sd1, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_REMOVE, 32'sd0, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, 32'sd0, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, 32'sd1, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_REMOVE, 32'h8000_0000, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_REMOVE, 32'h7FFF_FFFF, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_REMOVE, 32'h7FFF_FFFF, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, -32'sd1, 32'h0, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, 32'sd5, 32'h0000_0001, 0, 1'b0, 1'b0);
        add_req(OP_INSERT, 32'sd7, 32'h8000_0000, 0, 1'b0, 1'b0);
        add_req(OP_LOOKUP, 32'sd5, 32'hDEAD_BEEF, 0, 1'b0, 1'b0);
        add_req(OP_CLEAR, 32'sd0, 32'h0, 0, 1'b0, 1'b0);

        for (ph = 0; ph < 3; ph++)
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 48 == 0)
                    for (j = 0; j < POOL_SIZE; j++)
                        case ($urandom_range(3))
                            0: key_pool[j] = key_t'($urandom_range(16)) - 32'sd8;
                            1:
                            begin
                                case ($urandom_range(3))
                                    0: key_pool[j] = 32'h8000_0000;
                                    1: key_pool[j] = 32'h7FFF_FFFF;
                                    2: key_pool[j] = 32'sd0;
                                    default: key_pool[j] = -32'sd1;
                                endcase
                            end
                            default: key_pool[j] = $urandom;
                        endcase
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
                r = $urandom_range(99);
                if (r < 50)
                    add_req(OP_INSERT, k, $urandom, ph, n == 0, 1'b0);
                else
                begin
                    if ($urandom_range(99) < 15)
                        k = $urandom;
                    if (r < 74)
                        add_req(OP_LOOKUP, k, $urandom, ph, n == 0, 1'b0);
                    else if (r < 98)
                        add_req(OP_REMOVE, k, $urandom, ph, n == 0 || (ph == 2 && n == 240),
                                (ph == 0 && n == 100) || (ph == 2 && n == 40));
                    else
                        add_req(OP_CLEAR, k, $urandom, ph, n == 0, 1'b0);
                end
                if ((ph == 0 && n == 100) || (ph == 2 && n == 40))
                    req_queue[req_queue.size()-1].hold = 1'b1;
                if (ph == 2 && n == 240)
                    req_queue[req_queue.size()-1].drain = 1'b1;
            end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (req_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (20) @(negedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[sorted_key_bucket.f]
hw/rtl/skb_pkg.sv
hw/rtl/skb_cell.sv
hw/rtl/sorted_key_bucket.sv
tb/tb_sorted_key_bucket.sv
